[hw/rtl/hsv2rgb_pkg.sv]
package hsv2rgb_pkg;

	// hue range and sector size in degrees
	localparam logic [8:0]  HUE_FULL   = 9'd360;
	localparam logic [5:0]  SECTOR_DEG = 6'd60;

	// full-scale input channel
	localparam logic [7:0]  CHAN_MAX   = 8'd255;

	// channel = V * K * 257 / 15300, rounded to nearest with ties upward
	localparam logic [8:0]  SCALE_NUM  = 9'd257;
	localparam logic [13:0] SCALE_DEN  = 14'd15300;
	localparam logic [12:0] ROUND_BIAS = 13'd7650;

	// floor(x / 3825) == (x * DIV_RECIP) >> DIV_SHIFT for any 28-bit x,
	// with floor(m / 15300) == floor((m >> 2) / 3825)
	localparam logic [28:0] DIV_RECIP  = 29'd287454021;
	localparam int          DIV_SHIFT  = 40;

	// hexagon sectors, one per 60 degrees of hue
	typedef enum logic [2:0] {
		SEC_RED_YEL  = 3'd0,
		SEC_YEL_GRN  = 3'd1,
		SEC_GRN_CYN  = 3'd2,
		SEC_CYN_BLU  = 3'd3,
		SEC_BLU_MAG  = 3'd4,
		SEC_MAG_RED  = 3'd5
	} sector_t;

	// sector start angles
	localparam logic [8:0]  SEC1_DEG = 9'd60;
	localparam logic [8:0]  SEC2_DEG = 9'd120;
	localparam logic [8:0]  SEC3_DEG = 9'd180;
	localparam logic [8:0]  SEC4_DEG = 9'd240;
	localparam logic [8:0]  SEC5_DEG = 9'd300;

endpackage

[hw/rtl/hsv_to_rgb_converter.sv]
// HSV to RGB pixel converter.
//
// Input channel (in_valid / in_ready): one word per pixel holding hue in
// whole degrees (0..360, 360 acts as 0, larger codes wrap modulo 360),
// saturation and brightness (0..255 each).
// Output channel (out_valid / out_ready): one word per pixel holding red,
// green and blue, each the real intensity 0..1 times 65535, rounded.
//
// Throughput is one pixel per cycle: the five-stage pipeline (sector split,
// coefficient products, brightness products, rounding, reciprocal multiply
// and channel placement) advances as a whole whenever the output register
// is empty or being taken.
//
// When the receiver holds out_ready low with a word waiting, the whole
// pipeline freezes and in_ready drops in the same cycle; no word is lost
// or repeated. Reset clears all valid bits; data registers are not reset.
module hsv_to_rgb_converter
	import hsv2rgb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [8:0]  hue,
	input  logic [7:0]  saturation,
	input  logic [7:0]  brightness,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] red,
	output logic [15:0] green,
	output logic [15:0] blue
);

	logic        advance;

	logic        valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;

	sector_t     sector_s1, sector_s2, sector_s3, sector_s4;
	logic [5:0]  frac_s1;
	logic [7:0]  sat_s1;
	logic [7:0]  val_s1, val_s2;

	logic [13:0] kp_s2, kq_s2, kt_s2;

	logic [21:0] np_s3, nq_s3, nt_s3;
	logic [15:0] cv_s3, cv_s4;

	logic [27:0] mp_s4, mq_s4, mt_s4;

	logic [15:0] red_s5, green_s5, blue_s5;

	// stage 1 combinational
	logic [8:0]  hue_wrap;
	sector_t     sector_c;
	logic [8:0]  base_c;
	logic [8:0]  frac_wide;

	// stage 2 combinational
	logic [7:0]  sat_inv;
	logic [5:0]  frac_inv;

	// stage 4 combinational
	logic [29:0] mp_c, mq_c, mt_c;

	// stage 5 combinational
	logic [56:0] prod_p, prod_q, prod_t;
	logic [15:0] cp_c, cq_c, ct_c;

	// whole pipeline moves unless a finished word is stalled at the output
	assign advance  = !valid_s5 || out_ready;
	assign in_ready = advance;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// stage 1: wrap hue, split into sector and fraction
	always_comb begin
		hue_wrap = (hue >= HUE_FULL) ? (hue - HUE_FULL) : hue;
		if (hue_wrap < SEC1_DEG) begin
			sector_c = SEC_RED_YEL;
			base_c   = 9'd0;
		end else if (hue_wrap < SEC2_DEG) begin
			sector_c = SEC_YEL_GRN;
			base_c   = SEC1_DEG;
		end else if (hue_wrap < SEC3_DEG) begin
			sector_c = SEC_GRN_CYN;
			base_c   = SEC2_DEG;
		end else if (hue_wrap < SEC4_DEG) begin
			sector_c = SEC_CYN_BLU;
			base_c   = SEC3_DEG;
		end else if (hue_wrap < SEC5_DEG) begin
			sector_c = SEC_BLU_MAG;
			base_c   = SEC4_DEG;
		end else begin
			sector_c = SEC_MAG_RED;
			base_c   = SEC5_DEG;
		end
		frac_wide = hue_wrap - base_c;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sector_s1 <= sector_c;
			frac_s1   <= frac_wide[5:0];
			sat_s1    <= saturation;
			val_s1    <= brightness;
		end
	end

	// stage 2: coefficients for p, q and t
	assign sat_inv  = CHAN_MAX - sat_s1;
	assign frac_inv = SECTOR_DEG - frac_s1;

	always_ff @(posedge clk) begin
		if (advance) begin
			sector_s2 <= sector_s1;
			val_s2    <= val_s1;
			kp_s2     <= 14'(sat_inv) * 14'(SECTOR_DEG);
			kq_s2     <= SCALE_DEN - 14'(14'(sat_s1) * 14'(frac_s1));
			kt_s2     <= SCALE_DEN - 14'(14'(sat_s1) * 14'(frac_inv));
		end
	end

	// stage 3: brightness times coefficient; full value scales exactly
	always_ff @(posedge clk) begin
		if (advance) begin
			sector_s3 <= sector_s2;
			np_s3     <= 22'(val_s2) * 22'(kp_s2);
			nq_s3     <= 22'(val_s2) * 22'(kq_s2);
			nt_s3     <= 22'(val_s2) * 22'(kt_s2);
			cv_s3     <= 16'(16'(val_s2) * 16'(SCALE_NUM));
		end
	end

	// stage 4: scale by 257, add half divisor, drop the factor of four
	assign mp_c = (30'(np_s3) << 8) + 30'(np_s3) + 30'(ROUND_BIAS);
	assign mq_c = (30'(nq_s3) << 8) + 30'(nq_s3) + 30'(ROUND_BIAS);
	assign mt_c = (30'(nt_s3) << 8) + 30'(nt_s3) + 30'(ROUND_BIAS);

	always_ff @(posedge clk) begin
		if (advance) begin
			sector_s4 <= sector_s3;
			cv_s4     <= cv_s3;
			mp_s4     <= mp_c[29:2];
			mq_s4     <= mq_c[29:2];
			mt_s4     <= mt_c[29:2];
		end
	end

	// stage 5: divide by 3825 through the reciprocal, then place channels
	assign prod_p = 57'(mp_s4) * 57'(DIV_RECIP);
	assign prod_q = 57'(mq_s4) * 57'(DIV_RECIP);
	assign prod_t = 57'(mt_s4) * 57'(DIV_RECIP);
	assign cp_c   = prod_p[DIV_SHIFT +: 16];
	assign cq_c   = prod_q[DIV_SHIFT +: 16];
	assign ct_c   = prod_t[DIV_SHIFT +: 16];

	always_ff @(posedge clk) begin
		if (advance) begin
			case (sector_s4)
				SEC_RED_YEL: begin
					red_s5 <= cv_s4; green_s5 <= ct_c;  blue_s5 <= cp_c;
				end
				SEC_YEL_GRN: begin
					red_s5 <= cq_c;  green_s5 <= cv_s4; blue_s5 <= cp_c;
				end
				SEC_GRN_CYN: begin
					red_s5 <= cp_c;  green_s5 <= cv_s4; blue_s5 <= ct_c;
				end
				SEC_CYN_BLU: begin
					red_s5 <= cp_c;  green_s5 <= cq_c;  blue_s5 <= cv_s4;
				end
				SEC_BLU_MAG: begin
					red_s5 <= ct_c;  green_s5 <= cp_c;  blue_s5 <= cv_s4;
				end
				default: begin
					red_s5 <= cv_s4; green_s5 <= cp_c;  blue_s5 <= cq_c;
				end
			endcase
		end
	end

	assign out_valid = valid_s5;
	assign red       = red_s5;
	assign green     = green_s5;
	assign blue      = blue_s5;

`ifndef SYNTHESIS
	// an accepted word always lands in the first stage
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> valid_s1)
		else $error("accepted word missing from stage 1");

	// sector split keeps the fraction inside one sector
	a_frac_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (frac_s1 < SECTOR_DEG))
		else $error("hue fraction out of range");

	// q and t coefficients never exceed full scale
	a_coef_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (kq_s2 <= SCALE_DEN && kt_s2 <= SCALE_DEN))
		else $error("coefficient above full scale");

	// quotients fit in sixteen bits
	a_quot_fits: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> (prod_p[56] == 1'b0 && prod_q[56] == 1'b0
			&& prod_t[56] == 1'b0))
		else $error("channel quotient overflow");

	// a stalled output word freezes the stage behind it
	a_stall_freeze: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && !out_ready) |=> ($stable(valid_s4) && $stable(sector_s4)))
		else $error("pipeline moved under stall");
`endif

endmodule

[tb/sv/tb_top.sv]
module tb_top
	import hsv2rgb_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT   = 300000;
	localparam int DRAIN_CYCLES  = 12;
	localparam int LONG_HOLD_LEN = 300;

	typedef struct packed {
		logic [15:0] red;
		logic [15:0] green;
		logic [15:0] blue;
	} rgb_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [8:0]  hue = '0;
	logic [7:0]  saturation = '0;
	logic [7:0]  brightness = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] red;
	logic [15:0] green;
	logic [15:0] blue;

	// expected pixels in arrival order
	rgb_t rgb_expected[$];

	int unsigned cycle_count = 0;
	int unsigned mismatch_count = 0;
	int unsigned pixels_sent = 0;
	int unsigned pixels_checked = 0;
	int unsigned input_stalls = 0;

	// idling controls, source side owned by the stimulus process
	bit          src_idle_en = 1'b1;
	logic        sink_idle_en = 1'b1;
	int unsigned long_hold_len = 0;
	int unsigned long_hold_tag = 0;
	int unsigned hold_seen;
	int unsigned stall_left;

	hsv_to_rgb_converter dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.hue        (hue),
		.saturation (saturation),
		.brightness (brightness),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.red        (red),
		.green      (green),
		.blue       (blue)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// channel = V * K * 257 / 15300, rounded to nearest, ties upward
	function automatic logic [15:0] scale_channel(longint unsigned v, longint unsigned k);
		longint unsigned num;
		longint unsigned den;
		num = v * k * longint'(SCALE_NUM);
		den = longint'(SCALE_DEN);
		return 16'((2 * num + den) / (2 * den));
	endfunction

	// expected rgb for one hsv pixel
	function automatic rgb_t convert_pixel(logic [8:0] h_in, logic [7:0] s_in, logic [7:0] v_in);
		longint unsigned h;
		longint unsigned frac;
		longint unsigned s;
		longint unsigned v;
		sector_t sec;
		logic [15:0] cv, cp, cq, ct;
		rgb_t px;
		h = longint'(h_in) % longint'(HUE_FULL);
		sec = sector_t'(h / longint'(SECTOR_DEG));
		frac = h % longint'(SECTOR_DEG);
		s = s_in;
		v = v_in;
		cv = scale_channel(v, longint'(SCALE_DEN));
		cp = scale_channel(v, longint'(SECTOR_DEG) * (longint'(CHAN_MAX) - s));
		cq = scale_channel(v, longint'(SCALE_DEN) - s * frac);
		ct = scale_channel(v, longint'(SCALE_DEN) - s * (longint'(SECTOR_DEG) - frac));
		case (sec)
			SEC_RED_YEL: px = '{cv, ct, cp};
			SEC_YEL_GRN: px = '{cq, cv, cp};
			SEC_GRN_CYN: px = '{cp, cv, ct};
			SEC_CYN_BLU: px = '{cp, cq, cv};
			SEC_BLU_MAG: px = '{ct, cp, cv};
			default:     px = '{cv, cp, cq};
		endcase
		return px;
	endfunction

	// cycle counter and watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// output side: long holds on request, random stall bursts otherwise
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_left <= 0;
			hold_seen <= 0;
		end else if (long_hold_tag != hold_seen) begin
			hold_seen <= long_hold_tag;
			stall_left <= long_hold_len;
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 16);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	task automatic check_channel(string name, logic [15:0] exp_val, logic [15:0] act_val);
		if (exp_val !== act_val) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	// compare each output word with the oldest expected pixel
	always @(negedge clk) begin
		rgb_t exp_px;
		if (arst_n && out_valid && out_ready) begin
			if (rgb_expected.size() == 0) begin
				$error("unexpected output word: red %0d green %0d blue %0d", red, green, blue);
				mismatch_count++;
			end else begin
				exp_px = rgb_expected.pop_front();
				check_channel("red", exp_px.red, red);
				check_channel("green", exp_px.green, green);
				check_channel("blue", exp_px.blue, blue);
				pixels_checked++;
			end
		end
	end

	// offer one word, optionally after an idle burst; called at a rising edge
	task automatic send_pixel(logic [8:0] h, logic [7:0] s, logic [7:0] v);
		bit accepted;
		int unsigned gap;
		if (src_idle_en && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 17);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		hue <= h;
		saturation <= s;
		brightness <= v;
		forever begin
			@(negedge clk);
			accepted = in_ready;
			if (!accepted)
				input_stalls++;
			@(posedge clk);
			if (accepted)
				break;
		end
		rgb_expected.push_back(convert_pixel(h, s, v));
		pixels_sent++;
	endtask

	// random pixel, weighted toward legal hues and channel extremes
	task automatic random_pixel();
		logic [8:0] h;
		logic [7:0] s;
		logic [7:0] v;
		h = ($urandom_range(0, 6) == 0) ? 9'($urandom_range(0, 511))
			: 9'($urandom_range(0, 360));
		case ($urandom_range(0, 9))
			0:       s = 8'd0;
			1:       s = CHAN_MAX;
			default: s = 8'($urandom_range(0, 255));
		endcase
		case ($urandom_range(0, 9))
			0:       v = 8'd0;
			1:       v = CHAN_MAX;
			default: v = 8'($urandom_range(0, 255));
		endcase
		send_pixel(h, s, v);
	endtask

	task automatic wait_empty();
		while (rgb_expected.size() != 0)
			@(posedge clk);
	endtask

	// sector edges, hue wrap, out-of-range hues, channel extremes
	task automatic test_corners();
		logic [8:0] edge_hues[18] = '{9'd0, 9'd1, 9'd59, 9'd60, 9'd61, 9'd119,
			9'd120, 9'd179, 9'd180, 9'd239, 9'd240, 9'd299, 9'd300, 9'd359,
			9'd360, 9'd361, 9'd420, 9'd511};
		foreach (edge_hues[i])
			send_pixel(edge_hues[i], CHAN_MAX, CHAN_MAX);
		// zero saturation gives grey
		send_pixel(9'd100, 8'd0, 8'd200);
		send_pixel(9'd360, 8'd0, CHAN_MAX);
		// black, and tiny channels
		send_pixel(9'd200, CHAN_MAX, 8'd0);
		send_pixel(9'd30, 8'd1, 8'd1);
		send_pixel(9'd330, 8'd128, 8'd127);
		send_pixel(9'd90, 8'd170, 8'd85);
	endtask

	// random pixels in chunks, idling switched per chunk on each side
	task automatic test_random_stream(int unsigned chunks);
		repeat (chunks) begin
			src_idle_en = ($urandom_range(0, 3) != 0);
			sink_idle_en <= ($urandom_range(0, 3) != 0);
			repeat (50)
				random_pixel();
		end
	endtask

	// receiver holds off while the sender keeps offering words
	task automatic test_long_hold();
		src_idle_en = 1'b0;
		long_hold_len <= LONG_HOLD_LEN;
		long_hold_tag <= long_hold_tag + 1;
		repeat (40)
			random_pixel();
	endtask

	// sender pauses until the pipeline has drained, then resumes
	task automatic test_drain_pause();
		src_idle_en = 1'b1;
		repeat (3) begin
			repeat (20)
				random_pixel();
			in_valid <= 1'b0;
			wait_empty();
		end
	endtask

	// back-to-back words at full rate, no idling anywhere
	task automatic test_full_rate();
		src_idle_en = 1'b0;
		sink_idle_en <= 1'b0;
		repeat (150)
			random_pixel();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corners();
		test_random_stream(10);
		test_long_hold();
		test_drain_pause();
		test_full_rate();

		in_valid <= 1'b0;
		wait_empty();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("tb: %0d pixels sent, %0d words checked, %0d input stall cycles seen",
			pixels_sent, pixels_checked, input_stalls);
		$display("tb: covered sector edges, hue wrap, grey and black, long output hold, drain");
		if (mismatch_count == 0 && rgb_expected.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
